[rtl/cis_pkg.sv]
package cis_pkg;

  localparam int WEIGHT_W = 16;
  localparam int FRAC_W = 16;
  localparam int TOTAL_W = 26;
  localparam int PROD_W = TOTAL_W + FRAC_W;
  localparam int LEN_CFG_W = 11;
  localparam int IDX_W = 10;

  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int DEFAULT_LENGTH = 1024;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   uniform_frac;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] bucket_index;
    logic             zero_total;
  } result_t;

  // Control from the top level to the search sequencer.
  typedef struct packed {
    logic start;
    logic take;
  } srch_ctl_t;

  // Status from the search sequencer back to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } srch_stat_t;

endpackage

[rtl/cis_ram.sv]
module cis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cis_search.sv]
module cis_search #(
  parameter int MAX_BUCKETS = cis_pkg::MAX_BUCKETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cis_pkg::srch_ctl_t                ctl,
  output cis_pkg::srch_stat_t               stat,
  input  logic [cis_pkg::FRAC_W-1:0]        uniform_frac,
  input  logic [cis_pkg::TOTAL_W-1:0]       total,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]  n,
  output logic [$clog2(MAX_BUCKETS)-1:0]    raddr,
  input  logic [cis_pkg::TOTAL_W-1:0]       rdata,
  output logic [cis_pkg::IDX_W-1:0]         bucket_index,
  output logic                              zero_total
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int AW = $clog2(MAX_BUCKETS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SEARCH,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                       state;
  logic [cis_pkg::FRAC_W-1:0]   u_q;
  logic [cis_pkg::TOTAL_W-1:0]  total_q;
  logic [CNT_W-1:0]             n_q;
  logic [cis_pkg::PROD_W-1:0]   target;
  logic [CNT_W-1:0]             lo;
  logic [CNT_W-1:0]             hi;
  logic [CNT_W-1:0]             mid;
  logic                         p_zero;

  logic [cis_pkg::TOTAL_W-1:0]  p;
  logic [cis_pkg::PROD_W-1:0]   p_ext;
  logic                         ge;
  logic                         eq;
  logic [CNT_W-1:0]             lo_next;
  logic [CNT_W-1:0]             hi_next;
  logic [CNT_W:0]               mid_sum;
  logic [CNT_W-1:0]             mid_next;
  logic [CNT_W-1:0]             mid_first;
  logic                         more;
  logic [CNT_W-1:0]             probe;
  logic [CNT_W-1:0]             probe_m1;
  logic [CNT_W-1:0]             r_raw;
  logic [CNT_W-1:0]             n_m1;
  logic [CNT_W-1:0]             r_sel;
  logic [cis_pkg::PROD_W-1:0]   product;

  // The one compare unit: the probed prefix, scaled to the product's fraction.
  always_comb begin
    p = p_zero ? '0 : rdata;
    p_ext = {p, {cis_pkg::FRAC_W{1'b0}}};
    ge = (p_ext >= target);
    eq = (p_ext == target);
  end

  always_comb begin
    lo_next = ge ? lo : mid + CNT_W'(1);
    hi_next = ge ? mid : hi;
    mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = mid_sum[CNT_W:1];
    mid_first = n_q >> 1;
    more = (lo_next < hi_next);
    if (state == S_MUL) begin
      probe = mid_first;
    end else if (more) begin
      probe = mid_next;
    end else begin
      probe = lo_next;
    end
    probe_m1 = probe - CNT_W'(1);
    raddr = probe_m1[AW-1:0];
  end

  always_comb begin
    if (eq) begin
      r_raw = lo;
    end else if (lo == '0) begin
      r_raw = '0;
    end else begin
      r_raw = lo - CNT_W'(1);
    end
    n_m1 = n_q - CNT_W'(1);
    r_sel = (r_raw > n_m1) ? n_m1 : r_raw;
  end

  assign product = {{cis_pkg::TOTAL_W{1'b0}}, u_q} * {{cis_pkg::FRAC_W{1'b0}}, total_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            u_q <= uniform_frac;
            total_q <= total;
            n_q <= n;
            if (total == '0) begin
              bucket_index <= '0;
              zero_total <= 1'b1;
              state <= S_DONE;
            end else begin
              zero_total <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          target <= product;
          lo <= '0;
          hi <= n_q;
          mid <= mid_first;
          p_zero <= (mid_first == '0);
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          lo <= lo_next;
          hi <= hi_next;
          if (more) begin
            mid <= mid_next;
            p_zero <= (mid_next == '0);
          end else begin
            p_zero <= (lo_next == '0);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          bucket_index <= cis_pkg::IDX_W'(r_sel);
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule

[rtl/cdf_inverse_sampler.sv]
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   item (op, weight, uniform_frac)
// result    out        result_valid / result_stall  result (bucket_index, zero_total)
// cfg       in         cfg_valid / cfg_ready     cfg_data (length_in_use)
//
// A load item gives no result; loads can follow each other back to back.
// A draw item goes through a multiply step, then the steps of the binary
// search on the registered read port of the prefix memory, then a final
// equality check, and then it hands the result over. A draw with a zero
// total skips the multiply and the search and hands its result straight over.
// Reset (rst, synchronous) empties the distribution and sets the length to
// 1024, or to MAX_BUCKETS if that is smaller; the prefix memory is not cleared.
// While a draw is in progress item_stall is high and cfg_ready is low; a held
// result does not block loads, but a finished draw waits until the result
// register is free.
module cdf_inverse_sampler #(
  parameter int MAX_BUCKETS = cis_pkg::MAX_BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  cis_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output cis_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cis_pkg::LEN_CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int AW = $clog2(MAX_BUCKETS);
  localparam int RESET_LEN = (cis_pkg::DEFAULT_LENGTH > MAX_BUCKETS) ?
                             MAX_BUCKETS : cis_pkg::DEFAULT_LENGTH;

  logic [CNT_W-1:0]              length_in_use;
  logic [CNT_W-1:0]              load_count;
  logic [cis_pkg::TOTAL_W-1:0]   running_total;

  cis_pkg::srch_ctl_t            srch_ctl;
  cis_pkg::srch_stat_t           srch_stat;

  logic                          item_take;
  logic                          load;
  logic                          draw;
  logic                          cfg_take;
  logic [cis_pkg::TOTAL_W:0]     sum_wide;
  logic [cis_pkg::TOTAL_W-1:0]   sum_sat;
  logic [CNT_W-1:0]              load_count_inc;
  logic [CNT_W-1:0]              load_count_next;
  logic [CNT_W-1:0]              length_next;
  logic [CNT_W-1:0]              draw_n;
  logic [AW-1:0]                 ram_raddr;
  logic [cis_pkg::TOTAL_W-1:0]   ram_rdata;
  logic [cis_pkg::IDX_W-1:0]     srch_index;
  logic                          srch_zero;

  // Nothing new is taken while the search sequencer owns the prefix memory.
  assign item_stall = srch_stat.busy;
  assign cfg_ready = !srch_stat.busy;

  assign item_take = item_valid && !item_stall;
  assign load = item_take && (item.op == cis_pkg::OP_LOAD);
  assign draw = item_take && (item.op == cis_pkg::OP_DRAW);
  assign cfg_take = cfg_valid && cfg_ready;

  // The first weight of a distribution replaces the total; the sum saturates so
  // that the stored prefixes stay monotone.
  always_comb begin
    if (load_count == '0) begin
      sum_wide = {{(cis_pkg::TOTAL_W + 1 - cis_pkg::WEIGHT_W){1'b0}}, item.weight};
    end else begin
      sum_wide = {1'b0, running_total}
               + {{(cis_pkg::TOTAL_W + 1 - cis_pkg::WEIGHT_W){1'b0}}, item.weight};
    end
    sum_sat = sum_wide[cis_pkg::TOTAL_W] ? cis_pkg::TOTAL_MAX
                                         : sum_wide[cis_pkg::TOTAL_W-1:0];
    load_count_inc = load_count + CNT_W'(1);
    load_count_next = (load_count_inc >= length_in_use) ? '0 : load_count_inc;
  end

  // A length of zero is taken as one, and anything above the memory depth as
  // the depth itself.
  always_comb begin
    if (cfg_data == '0) begin
      length_next = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_BUCKETS)) begin
      length_next = CNT_W'(MAX_BUCKETS);
    end else begin
      length_next = CNT_W'(cfg_data);
    end
  end

  // A draw in the middle of loading samples the weights loaded so far.
  assign draw_n = (load_count == '0) ? length_in_use : load_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= CNT_W'(RESET_LEN);
      load_count <= '0;
      running_total <= '0;
    end else if (cfg_take) begin
      length_in_use <= length_next;
      load_count <= '0;
      running_total <= '0;
    end else if (load) begin
      load_count <= load_count_next;
      running_total <= sum_sat;
    end
  end

  cis_ram #(
    .WIDTH (cis_pkg::TOTAL_W),
    .DEPTH (MAX_BUCKETS)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (load),
    .waddr (load_count[AW-1:0]),
    .wdata (sum_sat),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign srch_ctl.start = draw;
  assign srch_ctl.take = srch_stat.done && (!result_valid || !result_stall);

  cis_search #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .ctl          (srch_ctl),
    .stat         (srch_stat),
    .uniform_frac (item.uniform_frac),
    .total        (running_total),
    .n            (draw_n),
    .raddr        (ram_raddr),
    .rdata        (ram_rdata),
    .bucket_index (srch_index),
    .zero_total   (srch_zero)
  );

  // Output register: a finished result waits here, so that loads can go on
  // while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (srch_ctl.take) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (srch_ctl.take) begin
      result.bucket_index <= srch_index;
      result.zero_total <= srch_zero;
    end
  end

endmodule

[rtl/cis_checker.sv]
module cis_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input cis_pkg::item_t                item,
  input logic                          result_valid,
  input logic                          result_stall,
  input cis_pkg::result_t              result,
  input logic                          cfg_ready
);

  // A held result keeps its value until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or vanished");

  // An empty distribution always reports bucket zero.
  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_total |-> result.bucket_index == '0)
    else $error("zero total with a nonzero bucket");

  // A draw occupies the block in the following cycle; a load never does.
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == cis_pkg::OP_DRAW |=> item_stall)
    else $error("draw did not stall the item channel");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == cis_pkg::OP_LOAD |=> !item_stall)
    else $error("load stalled the item channel");

  // Configuration is open exactly when items are.
  a_cfg_match: assert property (@(posedge clk) disable iff (rst)
    cfg_ready != item_stall)
    else $error("configuration and item channels disagree on busy");

endmodule

bind cdf_inverse_sampler cis_checker u_cis_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_ready    (cfg_ready)
);
